// File: rtl/suif_pkg.sv
// Package for the set union / intersection filter.
// Holds item kind codes, mode codes, default sizes and the controller state type.
// No dependencies.
package suif_pkg;

    localparam int SET_DEPTH_DEF = 16;
    localparam int VALUE_W       = 32;
    localparam int KIND_W        = 2;

    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FIRST  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SECOND = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SPARE  = 2'd3;

    localparam logic MODE_UNION = 1'b0;
    localparam logic MODE_INTER = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

endpackage

// File: rtl/suif_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Registered read data. No dependencies.
module suif_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/set_union_intersection_filter_core.sv
// Top level of the set union / intersection filter.
// Depends on suif_pkg and suif_ram.
//
// The block holds the first set in a RAM of SET_DEPTH entries and filters
// second-set values against it. Each request is handled on its own: a clear
// or a first-set request is accepted from the idle state; in union mode a
// first-set request then holds the input in the emit state while its value
// moves to the result register. A second-set request scans the stored
// entries one per cycle through the RAM's single read port, stopping at the
// first match; with an empty store it skips the scan and gives a result
// only in union mode. A request with a result also waits while the
// previous result is still stalled in the result register.
// The result register lets the next request enter while a result still waits
// to be taken. Nothing overlaps on the RAM: a write is done in the cycle its
// request is taken, before any later scan reads. The mode register is written
// only while the block is idle and no request is offered.
module set_union_intersection_filter_core #(
    parameter int SET_DEPTH = suif_pkg::SET_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [suif_pkg::KIND_W-1:0]         kind,
    input  logic signed [suif_pkg::VALUE_W-1:0] value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [suif_pkg::VALUE_W-1:0] value_res,
    output logic                                from_second,
    output logic                                store_overflowed,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                set_mode
);

    import suif_pkg::*;

    localparam int AW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
    localparam int CW = $clog2(SET_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(SET_DEPTH);

    state_t               state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic                 ovf_reg, ovf_next;
    logic                 mode_reg, mode_next;
    logic                 out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]   key_reg, key_next;
    logic [AW-1:0]        scan_idx_reg, scan_idx_next;
    logic [VALUE_W-1:0]   res_value_reg, res_value_next;
    logic                 res_second_reg, res_second_next;
    logic [VALUE_W-1:0]   out_value_reg, out_value_next;
    logic                 out_second_reg, out_second_next;
    logic                 out_ovf_reg, out_ovf_next;

    logic                 accept;
    logic                 store_full;
    logic                 ram_we;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [VALUE_W-1:0]   ram_rdata;
    logic                 hit;
    logic                 last;

    assign in_stall   = (state_reg != ST_IDLE);
    assign cfg_ready  = (state_reg == ST_IDLE) && !in_valid;
    assign accept     = in_valid && (state_reg == ST_IDLE);
    assign store_full = (count_reg >= DEPTH_C);
    assign ram_we     = accept && (kind == KIND_FIRST) && !store_full;
    assign hit        = (ram_rdata == key_reg);
    assign last       = ((CW'(scan_idx_reg) + CW'(1)) == count_reg);

    suif_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (SET_DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        mode_next       = mode_reg;
        key_next        = key_reg;
        scan_idx_next   = scan_idx_reg;
        res_value_next  = res_value_reg;
        res_second_next = res_second_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_value_next  = out_value_reg;
        out_second_next = out_second_reg;
        out_ovf_next    = out_ovf_reg;
        ram_re          = 1'b0;
        ram_raddr       = scan_idx_reg + AW'(1);

        if (cfg_valid && cfg_ready)
        begin
            mode_next = set_mode;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (kind)
                        KIND_CLEAR:
                        begin
                            count_next = '0;
                            ovf_next   = 1'b0;
                        end
                        KIND_FIRST:
                        begin
                            if (!store_full)
                            begin
                                count_next = count_reg + CW'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                            if (mode_reg == MODE_UNION)
                            begin
                                res_value_next  = value;
                                res_second_next = 1'b0;
                                state_next      = ST_EMIT;
                            end
                        end
                        KIND_SECOND:
                        begin
                            key_next = value;
                            if (count_reg == '0)
                            begin
                                if (mode_reg == MODE_UNION)
                                begin
                                    res_value_next  = value;
                                    res_second_next = 1'b1;
                                    state_next      = ST_EMIT;
                                end
                            end
                            else
                            begin
                                ram_re        = 1'b1;
                                ram_raddr     = '0;
                                scan_idx_next = '0;
                                state_next    = ST_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (hit || last)
                begin
                    if (hit == (mode_reg == MODE_INTER))
                    begin
                        res_value_next  = key_reg;
                        res_second_next = 1'b1;
                        state_next      = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    ram_re        = 1'b1;
                    scan_idx_next = scan_idx_reg + AW'(1);
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = res_value_reg;
                    out_second_next = res_second_reg;
                    out_ovf_next    = ovf_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            mode_reg      <= MODE_UNION;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            mode_reg      <= mode_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        scan_idx_reg   <= scan_idx_next;
        res_value_reg  <= res_value_next;
        res_second_reg <= res_second_next;
        out_value_reg  <= out_value_next;
        out_second_reg <= out_second_next;
        out_ovf_reg    <= out_ovf_next;
    end

    assign out_valid        = out_valid_reg;
    assign value_res        = out_value_reg;
    assign from_second      = out_second_reg;
    assign store_overflowed = out_ovf_reg;

endmodule

// File: rtl/suif_checker.sv
// Port-level assertions for the set union / intersection filter.
// Depends on suif_pkg; bound to set_union_intersection_filter_core below.
module suif_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_stall,
    input logic [suif_pkg::KIND_W-1:0]         kind,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic signed [suif_pkg::VALUE_W-1:0] value_res,
    input logic                                from_second,
    input logic                                store_overflowed,
    input logic                                cfg_ready
);

    import suif_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(value_res) && $stable(from_second)
             && $stable(store_overflowed)))
        else $error("result changed while stalled");

    // a new result only appears while a request is in progress
    a_res_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without a request in progress");

    // config is refused while a request is in progress
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> !cfg_ready)
        else $error("config ready while busy");

    // a clear request never produces a result
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (kind == KIND_CLEAR)) |=>
            (!in_stall ##1 !$rose(out_valid)))
        else $error("clear request produced a result");

endmodule

bind set_union_intersection_filter_core suif_checker u_suif_checker (.*);
